FILE: rtl/onoff_pkg.sv
// types, constants and saturating helpers shared by the on/off period statistics block
package onoff_pkg;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_SEARCH,
		S_LOAD,
		S_CAP,
		S_EVAL,
		S_MUL_GO,
		S_MUL_W,
		S_DIV_GO,
		S_DIV_W,
		S_RSQ_GO,
		S_RSQ_W,
		S_GSQ_GO,
		S_GSQ_W,
		S_UPD,
		S_WR,
		S_RD1,
		S_RD2,
		S_EMIT
	} state_t;

	// operations of the shared arithmetic unit
	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQ
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} alu_rsp_t;

	// open period of one user
	typedef struct packed {
		logic [47:0] start_us;
		logic [47:0] end_us;
		logic [47:0] bytes;
	} per_t;

	// running totals of one user
	typedef struct packed {
		logic [31:0] on_transfers;
		logic [31:0] off_times;
		logic [63:0] user_bytes;
		logic [63:0] on_duration_sum_us;
		logic [63:0] on_rate_sum;
		logic [63:0] on_rate_sq_sum;
		logic [47:0] max_on_rate;
		logic [63:0] off_duration_sum_us;
		logic [63:0] off_duration_sq_sum;
	} tot_t;

	// result status codes
	localparam logic [2:0] ST_EXTENDED   = 3'd0;
	localparam logic [2:0] ST_NEW_USER   = 3'd1;
	localparam logic [2:0] ST_CLOSED     = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_READ_OK    = 3'd4;
	localparam logic [2:0] ST_READ_EMPTY = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_SILENCE = 2'd0;
	localparam logic [1:0] CFG_TRACE_DUR   = 2'd1;
	localparam logic [1:0] CFG_SERVER_PORT = 2'd2;

	// reset values of the configuration registers
	localparam logic [31:0] RST_MAX_SILENCE = 32'd0;
	localparam logic [31:0] RST_TRACE_DUR   = 32'hFFFF_FFFF;
	localparam logic [15:0] RST_SERVER_PORT = 16'd80;

	// microseconds per second and the long ON period limit
	localparam logic [19:0] MICRO_SCALE = 20'd1000000;
	localparam logic [47:0] LONG_ON_US  = 48'd2000000;

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? {48{1'b1}} : s[47:0];
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] a);
		return (a == {32{1'b1}}) ? a : a + 32'd1;
	endfunction

endpackage

FILE: rtl/onoff_ram.sv
// generic single write port ram with registered read
module onoff_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/onoff_alu.sv
// shared bit-serial unit: multiply by one million, divide, saturating square
module onoff_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  onoff_pkg::alu_req_t  req,
	input  logic [47:0]          opa,
	output onoff_pkg::alu_rsp_t  rsp,
	output logic [63:0]          result
);

	localparam logic [6:0] MUL_STEPS = 7'($bits(onoff_pkg::MICRO_SCALE));
	localparam logic [6:0] DIV_STEPS = 7'd68;
	localparam logic [6:0] SQ_STEPS  = 7'd48;

	logic [67:0]         acc_q;
	logic [47:0]         rem_q;
	logic [47:0]         mcand_q;
	logic [47:0]         mplier_q;
	logic [6:0]          cnt_q;
	logic                done_q;
	logic                ovf_q;
	onoff_pkg::alu_op_t  op_q;

	logic [67:0] addend;
	logic [67:0] mac_sum;
	logic [48:0] trial;
	logic [48:0] diff;
	logic        ge;
	logic [47:0] rem_next;

	// one shift-add or one shift-subtract step
	always_comb begin
		addend   = mplier_q[47] ? {20'b0, mcand_q} : '0;
		mac_sum  = {acc_q[66:0], 1'b0} + addend;
		trial    = {rem_q, acc_q[67]};
		diff     = trial - {1'b0, mcand_q};
		ge       = trial >= {1'b0, mcand_q};
		rem_next = ge ? diff[47:0] : trial[47:0];
	end

	// step counter and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			done_q <= 1'b0;
			case (req.op)
				onoff_pkg::OP_MUL: cnt_q <= MUL_STEPS;
				onoff_pkg::OP_DIV: cnt_q <= DIV_STEPS;
				onoff_pkg::OP_SQ:  cnt_q <= SQ_STEPS;
				default:           cnt_q <= '0;
			endcase
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath; a divide keeps the product left in the accumulator as numerator
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q    <= req.op;
			mcand_q <= opa;
			ovf_q   <= 1'b0;
			case (req.op)
				onoff_pkg::OP_MUL: begin
					acc_q    <= '0;
					mplier_q <= {onoff_pkg::MICRO_SCALE, 28'b0};
				end
				onoff_pkg::OP_DIV: begin
					rem_q <= '0;
				end
				default: begin
					acc_q    <= '0;
					mplier_q <= opa;
				end
			endcase
		end else if (cnt_q != '0) begin
			case (op_q)
				onoff_pkg::OP_DIV: begin
					acc_q <= {acc_q[66:0], ge};
					rem_q <= rem_next;
				end
				default: begin
					acc_q    <= mac_sum;
					mplier_q <= {mplier_q[46:0], 1'b0};
					ovf_q    <= ovf_q | (|mac_sum[67:64]);
				end
			endcase
		end
	end

	assign result   = (op_q == onoff_pkg::OP_SQ && ovf_q) ? {64{1'b1}} : acc_q[63:0];
	assign rsp.done = done_q;
	assign rsp.busy = (cnt_q != '0);

endmodule

FILE: rtl/per_user_on_off_period_stats_core.sv
// top level: per-user on/off period statistics with sequential search and shared arithmetic
// sequence: a packet searches the filled entries in turn; closing an ON period over two seconds
//   adds a multiply, a divide, a rate square, a gap square and the update, other closing packets
//   only the gap square and update; a read of an empty entry skips the second read state
// throughput: one transaction at a time, set by the linear key search and the bit-serial unit
// reset: clears control state and the fill count; table entries at or above it read as empty
module per_user_on_off_period_stats_core #(
	parameter int USERS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [47:0] timestamp_us,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [15:0] pkt_length,
	input  logic [7:0]  entry_index,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        stop_request,
	output logic [31:0] user_addr,
	output logic [31:0] on_transfers,
	output logic [31:0] off_times,
	output logic [63:0] user_bytes,
	output logic [63:0] on_duration_sum_us,
	output logic [63:0] on_rate_sum,
	output logic [63:0] on_rate_sq_sum,
	output logic [47:0] max_on_rate,
	output logic [63:0] off_duration_sum_us,
	output logic [63:0] off_duration_sq_sum
);

	localparam int AW = $clog2(USERS);
	localparam int CW = $clog2(USERS + 1);
	localparam int XW = (CW > 8) ? CW : 8;

	onoff_pkg::state_t state_q, state_d;

	// control registers
	logic [31:0] max_silence_q;
	logic [31:0] trace_dur_q;
	logic [15:0] server_port_q;
	logic        started_q;
	logic [48:0] stop_time_q;
	logic [CW-1:0] fill_q;
	logic        out_valid_q;

	// working registers
	logic [47:0]   ts_q;
	logic [15:0]   len_q;
	logic [7:0]    idx_q;
	logic [31:0]   user_q;
	logic          stop_q;
	logic [2:0]    status_q;
	logic [CW-1:0] scan_q;
	logic          pend_q;
	logic [AW-1:0] hit_q;
	logic          create_q;
	logic          long_q;
	onoff_pkg::per_t per_q;
	onoff_pkg::tot_t tot_q;
	logic [47:0]   dur_q;
	logic [47:0]   gap_q;
	logic [47:0]   rate_q;
	logic [63:0]   rsq_q;
	logic [63:0]   gsq_q;

	// output registers
	logic [2:0]      out_status_q;
	logic            out_stop_q;
	logic [31:0]     out_user_q;
	onoff_pkg::tot_t out_tot_q;

	// memories and shared unit
	logic [31:0]         key_rd;
	onoff_pkg::per_t     per_rd;
	onoff_pkg::tot_t     tot_rd;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic                we_key;
	logic                we_rec;
	onoff_pkg::alu_req_t alu_req;
	onoff_pkg::alu_rsp_t alu_rsp;
	logic [47:0]         alu_a;
	logic [63:0]         alu_res;

	// derived conditions
	logic [48:0]   stop_sum;
	logic [48:0]   stop_base;
	logic          stop_now;
	logic          key_match;
	logic          scan_end;
	logic          full;
	logic [XW-1:0] idx_x;
	logic          rd_ok;
	logic          extend;
	logic          out_free;
	logic [CW-1:0] scan_prev;

	onoff_ram #(.WIDTH(32), .DEPTH(USERS)) u_key_ram (
		.clk   (clk),
		.we    (we_key),
		.waddr (waddr),
		.wdata (user_q),
		.raddr (raddr),
		.rdata (key_rd)
	);

	onoff_ram #(.WIDTH($bits(onoff_pkg::per_t)), .DEPTH(USERS)) u_per_ram (
		.clk   (clk),
		.we    (we_rec),
		.waddr (waddr),
		.wdata (per_q),
		.raddr (raddr),
		.rdata (per_rd)
	);

	onoff_ram #(.WIDTH($bits(onoff_pkg::tot_t)), .DEPTH(USERS)) u_tot_ram (
		.clk   (clk),
		.we    (we_rec),
		.waddr (waddr),
		.wdata (tot_q),
		.raddr (raddr),
		.rdata (tot_rd)
	);

	onoff_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_a),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	// condition logic
	always_comb begin
		stop_sum  = {1'b0, timestamp_us} + {17'b0, trace_dur_q};
		stop_base = started_q ? stop_time_q : stop_sum;
		stop_now  = {1'b0, timestamp_us} > stop_base;
		key_match = pend_q && (key_rd == user_q);
		scan_end  = (scan_q == fill_q);
		scan_prev = scan_q - CW'(1);
		full      = (fill_q == CW'(USERS));
		idx_x     = XW'(idx_q);
		rd_ok     = idx_x < XW'(fill_q);
		extend    = ({1'b0, per_q.end_us} + {17'b0, max_silence_q}) > {1'b0, ts_q};
		out_free  = !out_valid_q || !out_stall;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			onoff_pkg::S_IDLE: begin
				if (in_valid) state_d = action ? onoff_pkg::S_RD1 : onoff_pkg::S_SEARCH;
			end
			onoff_pkg::S_SEARCH: begin
				if (key_match) state_d = onoff_pkg::S_LOAD;
				else if (scan_end) state_d = full ? onoff_pkg::S_EMIT : onoff_pkg::S_WR;
			end
			onoff_pkg::S_LOAD: state_d = onoff_pkg::S_CAP;
			onoff_pkg::S_CAP:  state_d = onoff_pkg::S_EVAL;
			onoff_pkg::S_EVAL: begin
				if (extend) state_d = onoff_pkg::S_WR;
				else if (dur_q > onoff_pkg::LONG_ON_US) state_d = onoff_pkg::S_MUL_GO;
				else state_d = onoff_pkg::S_GSQ_GO;
			end
			onoff_pkg::S_MUL_GO: state_d = onoff_pkg::S_MUL_W;
			onoff_pkg::S_MUL_W: begin
				if (alu_rsp.done) state_d = onoff_pkg::S_DIV_GO;
			end
			onoff_pkg::S_DIV_GO: state_d = onoff_pkg::S_DIV_W;
			onoff_pkg::S_DIV_W: begin
				if (alu_rsp.done) state_d = onoff_pkg::S_RSQ_GO;
			end
			onoff_pkg::S_RSQ_GO: state_d = onoff_pkg::S_RSQ_W;
			onoff_pkg::S_RSQ_W: begin
				if (alu_rsp.done) state_d = onoff_pkg::S_GSQ_GO;
			end
			onoff_pkg::S_GSQ_GO: state_d = onoff_pkg::S_GSQ_W;
			onoff_pkg::S_GSQ_W: begin
				if (alu_rsp.done) state_d = onoff_pkg::S_UPD;
			end
			onoff_pkg::S_UPD: state_d = onoff_pkg::S_WR;
			onoff_pkg::S_WR:  state_d = onoff_pkg::S_EMIT;
			onoff_pkg::S_RD1: state_d = rd_ok ? onoff_pkg::S_RD2 : onoff_pkg::S_EMIT;
			onoff_pkg::S_RD2: state_d = onoff_pkg::S_EMIT;
			onoff_pkg::S_EMIT: begin
				if (out_free) state_d = onoff_pkg::S_IDLE;
			end
			default: state_d = onoff_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		raddr         = scan_q[AW-1:0];
		alu_req.start = 1'b0;
		alu_req.op    = onoff_pkg::OP_SQ;
		alu_a         = gap_q;
		we_key        = 1'b0;
		we_rec        = 1'b0;
		waddr         = create_q ? fill_q[AW-1:0] : hit_q;
		case (state_q)
			onoff_pkg::S_LOAD: raddr = hit_q;
			onoff_pkg::S_RD1:  raddr = idx_x[AW-1:0];
			onoff_pkg::S_MUL_GO: begin
				alu_req.start = 1'b1;
				alu_req.op    = onoff_pkg::OP_MUL;
				alu_a         = per_q.bytes;
			end
			onoff_pkg::S_DIV_GO: begin
				alu_req.start = 1'b1;
				alu_req.op    = onoff_pkg::OP_DIV;
				alu_a         = dur_q;
			end
			onoff_pkg::S_RSQ_GO: begin
				alu_req.start = 1'b1;
				alu_a         = rate_q;
			end
			onoff_pkg::S_GSQ_GO: begin
				alu_req.start = 1'b1;
			end
			onoff_pkg::S_WR: begin
				we_rec = 1'b1;
				we_key = create_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != onoff_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= onoff_pkg::S_IDLE;
			max_silence_q <= onoff_pkg::RST_MAX_SILENCE;
			trace_dur_q   <= onoff_pkg::RST_TRACE_DUR;
			server_port_q <= onoff_pkg::RST_SERVER_PORT;
			started_q     <= 1'b0;
			stop_time_q   <= '0;
			fill_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					onoff_pkg::CFG_MAX_SILENCE: max_silence_q <= cfg_data;
					onoff_pkg::CFG_TRACE_DUR:   trace_dur_q   <= cfg_data;
					onoff_pkg::CFG_SERVER_PORT: server_port_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			// first packet fixes the stop time
			if (state_q == onoff_pkg::S_IDLE && in_valid && !action && !started_q) begin
				started_q   <= 1'b1;
				stop_time_q <= stop_sum;
			end
			if (state_q == onoff_pkg::S_WR && create_q) begin
				fill_q <= fill_q + CW'(1);
			end
			if (state_q == onoff_pkg::S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		case (state_q)
			onoff_pkg::S_IDLE: begin
				if (in_valid) begin
					ts_q     <= timestamp_us;
					len_q    <= pkt_length;
					idx_q    <= entry_index;
					user_q   <= (src_port == server_port_q) ? dst_addr : src_addr;
					stop_q   <= action ? 1'b0 : stop_now;
					scan_q   <= '0;
					pend_q   <= 1'b0;
					create_q <= 1'b0;
				end
			end
			onoff_pkg::S_SEARCH: begin
				if (key_match) begin
					hit_q <= scan_prev[AW-1:0];
				end else if (scan_end) begin
					if (full) begin
						status_q <= onoff_pkg::ST_FULL;
						tot_q    <= '0;
					end else begin
						status_q       <= onoff_pkg::ST_NEW_USER;
						create_q       <= 1'b1;
						per_q.start_us <= ts_q;
						per_q.end_us   <= ts_q;
						per_q.bytes    <= {32'b0, len_q};
						tot_q          <= '{user_bytes: {48'b0, len_q}, default: '0};
					end
				end else begin
					scan_q <= scan_q + CW'(1);
					pend_q <= 1'b1;
				end
			end
			onoff_pkg::S_CAP: begin
				per_q <= per_rd;
				tot_q <= tot_rd;
				dur_q <= (per_rd.end_us >= per_rd.start_us) ?
				         per_rd.end_us - per_rd.start_us : '0;
			end
			onoff_pkg::S_EVAL: begin
				tot_q.user_bytes <= onoff_pkg::sat_add64(tot_q.user_bytes, {48'b0, len_q});
				long_q <= dur_q > onoff_pkg::LONG_ON_US;
				gap_q  <= ts_q - per_q.end_us;
				if (extend) begin
					status_q     <= onoff_pkg::ST_EXTENDED;
					per_q.bytes  <= onoff_pkg::sat_add48(per_q.bytes, {32'b0, len_q});
					per_q.end_us <= ts_q;
				end else begin
					status_q <= onoff_pkg::ST_CLOSED;
				end
			end
			onoff_pkg::S_DIV_W: begin
				if (alu_rsp.done) rate_q <= alu_res[47:0];
			end
			onoff_pkg::S_RSQ_W: begin
				if (alu_rsp.done) rsq_q <= alu_res;
			end
			onoff_pkg::S_GSQ_W: begin
				if (alu_rsp.done) gsq_q <= alu_res;
			end
			onoff_pkg::S_UPD: begin
				// long ON period is kept, the OFF gap always
				if (long_q) begin
					tot_q.on_duration_sum_us <=
						onoff_pkg::sat_add64(tot_q.on_duration_sum_us, {16'b0, dur_q});
					tot_q.on_rate_sum <= onoff_pkg::sat_add64(tot_q.on_rate_sum, {16'b0, rate_q});
					tot_q.on_rate_sq_sum <= onoff_pkg::sat_add64(tot_q.on_rate_sq_sum, rsq_q);
					tot_q.on_transfers <= onoff_pkg::sat_inc32(tot_q.on_transfers);
					if (rate_q > tot_q.max_on_rate) tot_q.max_on_rate <= rate_q;
				end
				tot_q.off_times <= onoff_pkg::sat_inc32(tot_q.off_times);
				tot_q.off_duration_sum_us <=
					onoff_pkg::sat_add64(tot_q.off_duration_sum_us, {16'b0, gap_q});
				tot_q.off_duration_sq_sum <=
					onoff_pkg::sat_add64(tot_q.off_duration_sq_sum, gsq_q);
				per_q.start_us <= ts_q;
				per_q.end_us   <= ts_q;
				per_q.bytes    <= {32'b0, len_q};
			end
			onoff_pkg::S_RD1: begin
				if (!rd_ok) begin
					status_q <= onoff_pkg::ST_READ_EMPTY;
					user_q   <= '0;
					tot_q    <= '0;
				end
			end
			onoff_pkg::S_RD2: begin
				status_q <= onoff_pkg::ST_READ_OK;
				user_q   <= key_rd;
				tot_q    <= tot_rd;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == onoff_pkg::S_EMIT && out_free) begin
			out_status_q <= status_q;
			out_stop_q   <= stop_q;
			out_user_q   <= user_q;
			out_tot_q    <= tot_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign status              = out_status_q;
	assign stop_request        = out_stop_q;
	assign user_addr           = out_user_q;
	assign on_transfers        = out_tot_q.on_transfers;
	assign off_times           = out_tot_q.off_times;
	assign user_bytes          = out_tot_q.user_bytes;
	assign on_duration_sum_us  = out_tot_q.on_duration_sum_us;
	assign on_rate_sum         = out_tot_q.on_rate_sum;
	assign on_rate_sq_sum      = out_tot_q.on_rate_sq_sum;
	assign max_on_rate         = out_tot_q.max_on_rate;
	assign off_duration_sum_us = out_tot_q.off_duration_sum_us;
	assign off_duration_sq_sum = out_tot_q.off_duration_sq_sum;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(USERS))
		else $error("fill count beyond table size");

	a_alu_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == onoff_pkg::S_MUL_W || state_q == onoff_pkg::S_DIV_W ||
		                  state_q == onoff_pkg::S_RSQ_W || state_q == onoff_pkg::S_GSQ_W))
		else $error("arithmetic unit finished outside a wait state");

	a_key_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		we_key |-> !full)
		else $error("new entry written into a full table");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not held off after a transaction");

endmodule
